/* design/elsc_pkg.sv */
package elsc_pkg;

	// Field widths.
	localparam int unsigned VW = 16;
	// Quotient bits of the correction divider; |delta| stays below 2^17.
	localparam int unsigned QUO_BITS = 18;

	localparam logic signed [20:0] SAT_MAX = 21'sd32767;
	localparam logic signed [20:0] SAT_MIN = -21'sd32768;

	typedef struct packed {
		logic signed [VW-1:0] a_pos_x;
		logic signed [VW-1:0] a_pos_y;
		logic signed [VW-1:0] a_pos_z;
		logic signed [VW-1:0] b_pos_x;
		logic signed [VW-1:0] b_pos_y;
		logic signed [VW-1:0] b_pos_z;
		logic signed [VW-1:0] a_vel_x;
		logic signed [VW-1:0] a_vel_y;
		logic signed [VW-1:0] a_vel_z;
		logic signed [VW-1:0] b_vel_x;
		logic signed [VW-1:0] b_vel_y;
		logic signed [VW-1:0] b_vel_z;
	} pair_t;

	typedef struct packed {
		logic signed [VW-1:0] a_new_vel_x;
		logic signed [VW-1:0] a_new_vel_y;
		logic signed [VW-1:0] a_new_vel_z;
		logic signed [VW-1:0] b_new_vel_x;
		logic signed [VW-1:0] b_new_vel_y;
		logic signed [VW-1:0] b_new_vel_z;
		logic                 a_at_rest;
		logic                 b_at_rest;
		logic                 coincident;
	} result_t;

endpackage

/* design/elastic_sphere_collision_core.sv */
// Equal-mass elastic collision of two spheres, one pair per clock while
// pair_stall is low. The pipeline centres on the restoring divider for
// s = (u.d)*d_i/|d|^2, which resolves one quotient bit per stage over 18 stages,
// after five stages of differences, products, sums, the wide numerator multiply
// and sign and magnitude, and before a rounding stage and an update and saturate
// stage. Every stage holds its own item while the output is stalled, so bubbles
// close up and pair_stall rises only when the whole pipeline is full.
// Coincident centres pass the velocities unchanged.
module elastic_sphere_collision_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	output logic             pair_stall,
	input  elsc_pkg::pair_t  pair,
	output logic             result_valid,
	input  logic             result_stall,
	output elsc_pkg::result_t result
);
	import elsc_pkg::*;

	localparam int unsigned DIV0 = 6;
	localparam int unsigned RND  = DIV0 + QUO_BITS;
	localparam int unsigned NSTG = RND + 1;

	logic [NSTG:1]   v_s;
	logic [NSTG+1:1] en;

	logic [5:0][VW-1:0] vel_s [1:NSTG-1];
	logic [NSTG-1:3]    coin_s;

	logic signed [16:0] d_s1 [3];
	logic signed [16:0] u_s1 [3];
	logic signed [16:0] d_s2 [3];
	logic signed [33:0] ud_s2 [3];
	logic        [33:0] dd_s2 [3];
	logic signed [16:0] d_s3 [3];
	logic signed [35:0] dot_s3;
	logic        [34:0] nsq_s3;
	logic signed [52:0] num_s4 [3];
	logic        [34:0] nsq_s4;
	logic        [51:0] mag_s5 [3];
	logic        [2:0]  neg_s5;
	logic        [34:0] nsq_s5;

	logic [51:0]          rem_s [0:QUO_BITS-1][3];
	logic [QUO_BITS-1:0]  quo_s [0:QUO_BITS-1][3];
	logic [2:0]           neg_s [0:QUO_BITS-1];
	logic [34:0]          den_s [0:QUO_BITS-1];

	logic signed [20:0] delta_s [3];

	// Each stage loads when it is empty or its successor moves on.
	always_comb begin
		en[NSTG+1] = !result_stall;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign pair_stall = !en[1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) begin
				v_s[1] <= pair_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	// Stage 1: differences of positions and velocities.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1[0] <= 17'(pair.a_pos_x) - 17'(pair.b_pos_x);
			d_s1[1] <= 17'(pair.a_pos_y) - 17'(pair.b_pos_y);
			d_s1[2] <= 17'(pair.a_pos_z) - 17'(pair.b_pos_z);
			u_s1[0] <= 17'(pair.a_vel_x) - 17'(pair.b_vel_x);
			u_s1[1] <= 17'(pair.a_vel_y) - 17'(pair.b_vel_y);
			u_s1[2] <= 17'(pair.a_vel_z) - 17'(pair.b_vel_z);
			vel_s[1] <= {pair.a_vel_x, pair.a_vel_y, pair.a_vel_z,
				pair.b_vel_x, pair.b_vel_y, pair.b_vel_z};
		end
	end

	// Stage 2: per-axis products for the dot product and the squared norm.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				ud_s2[i] <= 34'(u_s1[i] * d_s1[i]);
				dd_s2[i] <= 34'(d_s1[i] * d_s1[i]);
				d_s2[i]  <= d_s1[i];
			end
			vel_s[2] <= vel_s[1];
		end
	end

	// Stage 3: sums across the axes.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			dot_s3 <= 36'(ud_s2[0]) + 36'(ud_s2[1]) + 36'(ud_s2[2]);
			nsq_s3 <= 35'(dd_s2[0]) + 35'(dd_s2[1]) + 35'(dd_s2[2]);
			coin_s[3] <= (dd_s2[0] == '0) && (dd_s2[1] == '0) && (dd_s2[2] == '0);
			d_s3 <= d_s2;
			vel_s[3] <= vel_s[2];
		end
	end

	// Stage 4: numerator (u.d) * d_i for each axis.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= 53'(dot_s3 * d_s3[i]);
			end
			nsq_s4 <= nsq_s3;
			coin_s[4] <= coin_s[3];
			vel_s[4] <= vel_s[3];
		end
	end

	// Stage 5: sign and magnitude of each numerator.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				neg_s5[i] <= num_s4[i][52];
				mag_s5[i] <= num_s4[i][52] ? 52'(-num_s4[i]) : num_s4[i][51:0];
			end
			nsq_s5 <= nsq_s4;
			coin_s[5] <= coin_s[4];
			vel_s[5] <= vel_s[4];
		end
	end

	// Divider: one restoring step per stage, most significant quotient bit first.
	always_ff @(posedge clk) begin
		for (int k = 0; k < QUO_BITS; k++) begin
			if (en[DIV0+k]) begin
				for (int i = 0; i < 3; i++) begin
					logic [51:0] rin;
					logic [QUO_BITS-1:0] qin;
					logic [51:0] trial;
					rin = (k == 0) ? mag_s5[i] : rem_s[(k == 0) ? 0 : k-1][i];
					qin = (k == 0) ? '0 : quo_s[(k == 0) ? 0 : k-1][i];
					trial = 52'({17'd0, ((k == 0) ? nsq_s5 : den_s[(k == 0) ? 0 : k-1])})
						<< (QUO_BITS - 1 - k);
					if (rin >= trial) begin
						rem_s[k][i] <= rin - trial;
						quo_s[k][i] <= qin | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
					end else begin
						rem_s[k][i] <= rin;
						quo_s[k][i] <= qin;
					end
				end
				neg_s[k] <= (k == 0) ? neg_s5 : neg_s[(k == 0) ? 0 : k-1];
				den_s[k] <= (k == 0) ? nsq_s5 : den_s[(k == 0) ? 0 : k-1];
				coin_s[DIV0+k] <= coin_s[DIV0+k-1];
				vel_s[DIV0+k] <= vel_s[DIV0+k-1];
			end
		end
	end

	// Round to nearest, ties away from zero, then restore the sign.
	always_ff @(posedge clk) begin
		if (en[RND]) begin
			for (int i = 0; i < 3; i++) begin
				logic [20:0] qr;
				qr = 21'(quo_s[QUO_BITS-1][i]) +
					21'({rem_s[QUO_BITS-1][i][34:0], 1'b0} >= {1'b0, den_s[QUO_BITS-1]});
				delta_s[i] <= neg_s[QUO_BITS-1][i] ? -$signed(qr) : $signed(qr);
			end
			coin_s[RND] <= coin_s[RND-1];
			vel_s[RND] <= vel_s[RND-1];
		end
	end

	// Final stage: apply the correction, saturate and flag rest.
	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			logic signed [15:0] na [3];
			logic signed [15:0] nb [3];
			logic signed [20:0] ta;
			logic signed [20:0] tb;
			for (int i = 0; i < 3; i++) begin
				ta = 21'($signed(vel_s[RND][5-i])) - delta_s[i];
				tb = 21'($signed(vel_s[RND][2-i])) + delta_s[i];
				if (coin_s[RND]) begin
					na[i] = vel_s[RND][5-i];
					nb[i] = vel_s[RND][2-i];
				end else begin
					na[i] = (ta > SAT_MAX) ? 16'sh7fff : (ta < SAT_MIN) ? 16'sh8000 : ta[15:0];
					nb[i] = (tb > SAT_MAX) ? 16'sh7fff : (tb < SAT_MIN) ? 16'sh8000 : tb[15:0];
				end
			end
			result.a_new_vel_x <= na[0];
			result.a_new_vel_y <= na[1];
			result.a_new_vel_z <= na[2];
			result.b_new_vel_x <= nb[0];
			result.b_new_vel_y <= nb[1];
			result.b_new_vel_z <= nb[2];
			result.a_at_rest <= (na[0] == '0) && (na[1] == '0) && (na[2] == '0);
			result.b_at_rest <= (nb[0] == '0) && (nb[1] == '0) && (nb[2] == '0);
			result.coincident <= coin_s[RND];
		end
	end

	assign result_valid = v_s[NSTG];

	// An empty first stage always takes a request.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s[1] |-> !pair_stall) else $error("stall raised with an empty entry stage");

	// The divider remainder ends below the divisor for real centres.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[RND-1] && !coin_s[RND-1]) |->
		(rem_s[QUO_BITS-1][0] < 52'(den_s[QUO_BITS-1])))
		else $error("divider remainder out of range");

	// A stalled result is never dropped.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("stalled result lost");

endmodule
